// ===== sv/perlin_noise_2d_octaves_defines.svh =====
// Assertion macros used by the noise generator top level.
`ifndef PERLIN_NOISE_2D_OCTAVES_DEFINES_SVH
`define PERLIN_NOISE_2D_OCTAVES_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PN2O_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PN2O_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pn2o_pkg.sv =====
// Shared constants and helper functions for the 2D multi-octave noise generator.
package pn2o_pkg;

  localparam int QB = 17;         // quotient bits produced by the divider
  localparam int NUM_SHIFT = 14;  // output scale 2^14

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
    8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
    8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
    8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
    8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
    8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
    8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,
    8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
    8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
    8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
    8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
    8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,
    8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
    8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
    8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
    8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
    8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM[idx];
  endfunction

  // improved-noise gradient dot product, inputs signed Q.16
  function automatic logic signed [18:0] grad(input logic [7:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y);
    logic signed [18:0] u;
    logic signed [18:0] v;
    logic [3:0] hl;
    hl = h[3:0];
    u = (hl < 4'd8) ? 19'(x) : 19'(y);
    v = (hl < 4'd4) ? 19'(y) : 19'(x);
    if (hl[0]) u = -u;
    if (hl[1]) v = -v;
    return u + v;
  endfunction

endpackage

// ===== sv/pn2o_cell.sv =====
// Five-stage pipeline computing one octave of 2D improved noise.
module pn2o_cell import pn2o_pkg::*; #(
  parameter int OCT = 0,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        coord_x,
  input  logic [23:0]        coord_y,
  output logic signed [19:0] val
);

  localparam int SW = 24 + OCT + FRAC_BITS + 8;

  logic [SW-1:0] sx, sy;
  logic [FRAC_BITS+15:0] fxw, fyw;
  logic [7:0] xi_c, yi_c;

  always_comb begin
    sx = SW'(coord_x) << OCT;
    sy = SW'(coord_y) << OCT;
    xi_c = sx[FRAC_BITS +: 8];
    yi_c = sy[FRAC_BITS +: 8];
    fxw = {sx[FRAC_BITS-1:0], 16'd0};
    fyw = {sy[FRAC_BITS-1:0], 16'd0};
  end

  // stage 1: cell, fraction, first hash, t^2
  logic [7:0]  s1_yi, s1_pa, s1_pb;
  logic [15:0] s1_fx, s1_fy, s1_t2x, s1_t2y;
  logic [31:0] sqx, sqy;
  assign sqx = 32'(fxw[FRAC_BITS+15:FRAC_BITS]) * 32'(fxw[FRAC_BITS+15:FRAC_BITS]);
  assign sqy = 32'(fyw[FRAC_BITS+15:FRAC_BITS]) * 32'(fyw[FRAC_BITS+15:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_yi  <= yi_c;
      s1_pa  <= perm_lookup(xi_c);
      s1_pb  <= perm_lookup(xi_c + 8'd1);
      s1_fx  <= fxw[FRAC_BITS+15:FRAC_BITS];
      s1_fy  <= fyw[FRAC_BITS+15:FRAC_BITS];
      s1_t2x <= sqx[31:16];
      s1_t2y <= sqy[31:16];
    end
  end

  // stage 2: corner hashes, t^3 and fade polynomial
  logic [7:0]  s2_aa, s2_ab, s2_ba, s2_bb;
  logic [15:0] s2_fx, s2_fy, s2_t3x, s2_t3y;
  logic [19:0] s2_px, s2_py;
  logic [31:0] cbx, cby;
  logic [20:0] px_c, py_c;
  assign cbx = 32'(s1_t2x) * 32'(s1_fx);
  assign cby = 32'(s1_t2y) * 32'(s1_fy);
  assign px_c = 21'(s1_t2x) * 21'd6 + 21'd655360 - 21'(s1_fx) * 21'd15;
  assign py_c = 21'(s1_t2y) * 21'd6 + 21'd655360 - 21'(s1_fy) * 21'd15;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_aa  <= perm_lookup(s1_pa + s1_yi);
      s2_ab  <= perm_lookup(s1_pa + s1_yi + 8'd1);
      s2_ba  <= perm_lookup(s1_pb + s1_yi);
      s2_bb  <= perm_lookup(s1_pb + s1_yi + 8'd1);
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_t3x <= cbx[31:16];
      s2_t3y <= cby[31:16];
      s2_px  <= px_c[19:0];
      s2_py  <= py_c[19:0];
    end
  end

  // stage 3: fade weights and corner gradients
  logic [16:0] s3_u, s3_v;
  logic signed [18:0] s3_gaa, s3_gab, s3_gba, s3_gbb;
  logic [35:0] fdx, fdy;
  logic signed [17:0] ox0, ox1, oy0, oy1;
  assign fdx = 36'(s2_t3x) * 36'(s2_px);
  assign fdy = 36'(s2_t3y) * 36'(s2_py);
  assign ox0 = $signed({2'b00, s2_fx});
  assign oy0 = $signed({2'b00, s2_fy});
  assign ox1 = ox0 - 18'sd65536;
  assign oy1 = oy0 - 18'sd65536;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_u   <= fdx[32:16];
      s3_v   <= fdy[32:16];
      s3_gaa <= grad(s2_aa, ox0, oy0);
      s3_gba <= grad(s2_ba, ox1, oy0);
      s3_gab <= grad(s2_ab, ox0, oy1);
      s3_gbb <= grad(s2_bb, ox1, oy1);
    end
  end

  // stage 4: lerp along x
  logic [16:0] s4_v;
  logic signed [19:0] s4_lo, s4_hi;
  logic signed [19:0] dlo, dhi;
  logic signed [37:0] mlo, mhi;
  logic signed [21:0] lo_c, hi_c;
  always_comb begin
    dlo = 20'(s3_gba) - 20'(s3_gaa);
    dhi = 20'(s3_gbb) - 20'(s3_gab);
    mlo = $signed({1'b0, s3_u}) * dlo;
    mhi = $signed({1'b0, s3_u}) * dhi;
    lo_c = 22'(s3_gaa) + $signed(mlo[37:16]);
    hi_c = 22'(s3_gab) + $signed(mhi[37:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_v  <= s3_v;
      s4_lo <= lo_c[19:0];
      s4_hi <= hi_c[19:0];
    end
  end

  // stage 5: lerp along y
  logic signed [20:0] dv;
  logic signed [38:0] mv;
  logic signed [22:0] v_c;
  always_comb begin
    dv = 21'(s4_hi) - 21'(s4_lo);
    mv = $signed({1'b0, s4_v}) * dv;
    v_c = 23'(s4_lo) + $signed(mv[38:16]);
  end

  always_ff @(posedge clk) begin
    if (en) val <= v_c[19:0];
  end

endmodule

// ===== sv/pn2o_div.sv =====
// Pipelined restoring divider: |total|*2^14 / weight, one quotient bit per stage.
module pn2o_div import pn2o_pkg::*; #(
  parameter int NW = 25,
  parameter int DW = 21
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] total,
  input  logic [DW-1:0]        weight,
  output logic [QB-1:0]        q,
  output logic                 neg,
  output logic                 ovf
);

  localparam int RW = NW + NUM_SHIFT + DW + QB;

  logic [RW-1:0] rem [QB+1];
  logic [QB-1:0] qs  [QB+1];
  logic          ng  [QB+1];
  logic          ov  [QB+1];

  logic [NW-1:0] mag;
  assign mag = total[NW-1] ? NW'(-total) : NW'(total);

  // entry: magnitude, sign and out-of-range check (quotient >= 2^QB)
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(mag) << NUM_SHIFT;
      qs[0]  <= '0;
      ng[0]  <= total[NW-1];
      ov[0]  <= (RW'(mag) << NUM_SHIFT) >= (RW'(weight) << QB);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(weight) << B;
    assign ge  = rem[k] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - dsh : rem[k];
        qs[k+1]  <= qs[k] | (ge ? (QB'(1) << B) : '0);
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  assign q   = qs[QB];
  assign neg = ng[QB];
  assign ovf = ov[QB];

endmodule

// ===== sv/perlin_noise_2d_octaves.sv =====
// Result path from input transfer: noise lanes, weighting products, their sum, divider, output register.
// Throughput: one coordinate per cycle while in_stall is low; every octave has its own noise lane.
// A stalled output holds the whole pipeline; nothing is dropped.
// After reset and after any register write the input stalls while the octave
// amplitude chain and weight sum settle.
// Reset: synchronous; registers return to octave_count 6, persistence 0.5.
module perlin_noise_2d_octaves import pn2o_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [15:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        coord_x,
  input  logic [23:0]        coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value
);

  `include "perlin_noise_2d_octaves_defines.svh"

  localparam logic WR_OCTAVES = 1'b0;
  localparam logic WR_PERSIST = 1'b1;
  localparam int SETTLE = 2 * MAX_OCTAVES + 3;
  localparam int CW = $clog2(SETTLE + 1);
  localparam int WW = 17 + $clog2(MAX_OCTAVES + 1);
  localparam int PW = 22;
  localparam int TW = PW + $clog2(MAX_OCTAVES + 1);
  localparam int LAT = 5 + 2 + QB + 1 + 1;
  localparam int OW = $clog2(MAX_OCTAVES + 1) + 1;

  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [CW-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd6;
      persistence  <= 16'd32768;
      settle       <= CW'(SETTLE);
    end else if (wr_en) begin
      unique case (wr_index)
        WR_OCTAVES: octave_count <= wr_data[3:0];
        WR_PERSIST: persistence  <= wr_data;
        default: ;
      endcase
      settle <= CW'(SETTLE);
    end else if (settle != '0) begin
      settle <= settle - CW'(1);
    end
  end

  // clamp octave count to 1..MAX_OCTAVES
  logic [OW-1:0] n_eff;
  always_comb begin
    if (octave_count == 4'd0) n_eff = OW'(1);
    else if (OW'(octave_count) > OW'(MAX_OCTAVES)) n_eff = OW'(MAX_OCTAVES);
    else n_eff = OW'(octave_count);
  end

  // amplitude chain and weight sum, one register per step
  logic [16:0]   amp  [MAX_OCTAVES];
  logic [16:0]   ampe [MAX_OCTAVES];
  logic [WW-1:0] wacc [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
    if (i == 0) begin : g_first
      assign amp[i] = 17'd65536;
      always_ff @(posedge clk) begin
        ampe[i] <= amp[i];
        wacc[i] <= WW'(ampe[i]);
      end
    end else begin : g_rest
      logic [32:0] am;
      assign am = 33'(amp[i-1]) * 33'(persistence);
      always_ff @(posedge clk) begin
        amp[i]  <= am[32:16];
        ampe[i] <= (OW'(i) < n_eff) ? amp[i] : 17'd0;
        wacc[i] <= wacc[i-1] + WW'(ampe[i]);
      end
    end
  end

  logic adv;
  logic [LAT-1:0] vld;
  logic in_xfer;

  assign adv      = !(vld[LAT-1] && out_stall);
  assign in_stall = !adv || (settle != '0);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], in_xfer};
  end

  // octave lanes
  logic signed [19:0] val [MAX_OCTAVES];
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    pn2o_cell #(.OCT(i), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk     (clk),
      .en      (adv),
      .coord_x (coord_x),
      .coord_y (coord_y),
      .val     (val[i])
    );
  end

  // weighting and sum
  logic signed [PW-1:0] prod [MAX_OCTAVES];
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_prod
    logic signed [37:0] pm;
    assign pm = val[i] * $signed({1'b0, ampe[i]});
    always_ff @(posedge clk) begin
      if (adv) prod[i] <= pm[37:16];
    end
  end

  logic signed [TW-1:0] sum_c, total;
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) sum_c = sum_c + TW'(prod[i]);
  end

  always_ff @(posedge clk) begin
    if (adv) total <= sum_c;
  end

  logic [QB-1:0] q;
  logic neg, ovf;

  pn2o_div #(.NW(TW), .DW(WW)) u_div (
    .clk    (clk),
    .en     (adv),
    .total  (total),
    .weight (wacc[MAX_OCTAVES-1]),
    .q      (q),
    .neg    (neg),
    .ovf    (ovf)
  );

  // sign and saturation
  logic signed [15:0] res_c;
  logic signed [QB:0] nq;
  always_comb begin
    nq = -$signed({1'b0, q});
    if (!neg) begin
      if (ovf || q > QB'(32767)) res_c = 16'sh7fff;
      else res_c = q[15:0];
    end else begin
      if (ovf || q > QB'(32768)) res_c = -16'sh8000;
      else res_c = nq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) noise_value <= res_c;
  end

  assign out_valid = vld[LAT-1];

  `PN2O_ASSERT_NOW(a_settle_stall, settle != '0, in_stall, "input open while settling")
  `PN2O_ASSERT_NEXT(a_write_stall, wr_en, in_stall, "input open after register write")
  `PN2O_ASSERT_NEXT(a_hold_pipe, vld[LAT-1] && out_stall, $stable(vld), "pipeline moved under stall")

endmodule

// ===== verif/pn2o_tb_pkg.sv =====
// Register indexes shared by the noise generator testbench files.
package pn2o_tb_pkg;
  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_PERSISTENCE  = 1'b1;
endpackage

// ===== verif/perlin_noise_2d_octaves_checker.sv =====
// Noise generator checker: predicts each sample from the coordinates and compares results.
module perlin_noise_2d_octaves_checker import pn2o_tb_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [15:0]        wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [23:0]        coord_x,
  input  logic [23:0]        coord_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] noise_value,
  output int                 fail_count,
  output int                 pending
);

  logic [3:0]  octaves;
  logic [15:0] persist;
  logic signed [15:0] noise_q[$];

  function automatic longint fade(longint t);
    longint unsigned ut, t2, t3, p;
    ut = t;
    t2 = (ut * ut) >> 16;
    t3 = (t2 * ut) >> 16;
    p = 6 * t2 + 10 * 65536 - 15 * ut;
    return longint'((t3 * p) >> 16);
  endfunction

  function automatic longint lerp(longint w, longint a, longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint corner_dot(logic [7:0] h, longint x, longint y);
    longint u, v;
    u = (h[3:0] < 8) ? x : y;
    v = (h[3:0] < 4) ? y : x;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint cell_noise(longint unsigned cx, longint unsigned cy);
    logic [7:0] xi, yi, pa, pb, aa, ab, ba, bb;
    longint fx, fy, u, v, lo, hi;
    xi = cx[23:16];
    yi = cy[23:16];
    fx = longint'(cx[15:0]);
    fy = longint'(cy[15:0]);
    u = fade(fx);
    v = fade(fy);
    pa = pn2o_pkg::PERM[xi];
    pb = pn2o_pkg::PERM[8'(xi + 8'd1)];
    aa = pn2o_pkg::PERM[8'(pa + yi)];
    ab = pn2o_pkg::PERM[8'(pa + yi + 8'd1)];
    ba = pn2o_pkg::PERM[8'(pb + yi)];
    bb = pn2o_pkg::PERM[8'(pb + yi + 8'd1)];
    lo = lerp(u, corner_dot(aa, fx, fy), corner_dot(ba, fx - 65536, fy));
    hi = lerp(u, corner_dot(ab, fx, fy - 65536), corner_dot(bb, fx - 65536, fy - 65536));
    return lerp(v, lo, hi);
  endfunction

  function automatic logic signed [15:0] fbm_noise(logic [23:0] x, logic [23:0] y);
    int n;
    longint total, weight, amp, res;
    n = octaves;
    if (n < 1) n = 1;
    if (n > MAX_OCTAVES) n = MAX_OCTAVES;
    total = 0;
    weight = 0;
    amp = 65536;
    for (int i = 0; i < n; i++) begin
      total += (cell_noise(longint'(x) << i, longint'(y) << i) * amp) >>> 16;
      weight += amp;
      amp = (amp * longint'(persist)) >> 16;
    end
    res = (total * 16384) / weight;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return 16'(res);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      octaves <= 4'd6;
      persist <= 16'd32768;
      noise_q.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_OCTAVE_COUNT) octaves <= wr_data[3:0];
        else persist <= wr_data;
      end
      if (in_valid && !in_stall) noise_q.push_back(fbm_noise(coord_x, coord_y));
      if (out_valid && !out_stall) begin
        if (noise_q.size() == 0) report_mismatch("unexpected noise_value", noise_value, 0);
        else begin
          logic signed [15:0] want;
          want = noise_q.pop_front();
          if (noise_value !== want) report_mismatch("noise_value", noise_value, want);
        end
      end
    end
    pending <= noise_q.size();
  end

endmodule

// ===== verif/perlin_noise_2d_octaves_tb.sv =====
// Testbench top for the noise generator: clock, reset, stimulus and verdict.
module perlin_noise_2d_octaves_tb import pn2o_tb_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic wr_index = REG_OCTAVE_COUNT;
  logic [15:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] coord_x = '0;
  logic [23:0] coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] noise_value;
  int fail_count, pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic in_taken = 1'b0;

  always #5 clk = ~clk;

  perlin_noise_2d_octaves dut (.*);

  perlin_noise_2d_octaves_checker checker_i (.*);

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  task automatic write_reg(logic idx, logic [15:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // wait for all results, then let the pipeline run empty
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic configure(logic [3:0] octs, logic [15:0] pers);
    drain();
    write_reg(REG_OCTAVE_COUNT, 16'(octs));
    write_reg(REG_PERSISTENCE, pers);
  endtask

  task automatic send_coord(logic [23:0] x, logic [23:0] y);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    coord_x = x;
    coord_y = y;
    do @(negedge clk); while (!in_taken);
    in_valid = 1'b0;
  endtask

  task automatic random_block(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_coord(24'($urandom), 24'($urandom));
        // stay near cell corners and edges
        1: send_coord({8'($urandom_range(255)), ($urandom_range(1) ? 16'h0000 : 16'hFFFF)},
                      {8'($urandom), 16'($urandom_range(3))});
        default: send_coord(24'($urandom), 24'($urandom));
      endcase
    end
  endtask

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    // directed: field extremes, cell boundaries, wrap
    send_coord(24'h000000, 24'h000000);
    send_coord(24'hFFFFFF, 24'hFFFFFF);
    send_coord(24'hFFFFFF, 24'h000000);
    send_coord(24'h000000, 24'hFFFFFF);
    send_coord(24'h00FFFF, 24'h010000);
    send_coord(24'h008000, 24'h008000);
    send_coord(24'hFF8000, 24'hFF4000);
    send_coord(24'h7F0001, 24'h80FFFE);
    configure(4'd1, 16'd0);
    send_coord(24'h123456, 24'h654321);
    send_coord(24'hFFFFFF, 24'h00FFFF);
    configure(4'd0, 16'hFFFF);
    send_coord(24'h0A8000, 24'h031234);
    send_coord(24'hFFFFFF, 24'hFFFFFF);
    configure(4'd15, 16'hFFFF);
    send_coord(24'h0A8000, 24'h031234);
    send_coord(24'hFFFFFF, 24'hFFFFFF);
    configure(4'd8, 16'd0);
    send_coord(24'h5A5A5A, 24'hA5A5A5);
    configure(4'd9, 16'd1);
    send_coord(24'hC3C3C3, 24'h3C3C3C);

    tx_idle_pct = 7;
    rx_idle_pct = 87;
    configure(4'd6, 16'd32768);
    random_block(90);
    configure(4'd8, 16'hFFFF);
    random_block(90);

    tx_idle_pct = 87;
    rx_idle_pct = 7;
    configure(4'd2, 16'($urandom));
    random_block(90);
    configure(4'($urandom), 16'($urandom));
    random_block(90);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(4'd4, 16'd49152);
    random_block(50);
    // hold off until the pipeline has emptied
    while (pending != 0) @(negedge clk);
    random_block(50);
    configure(4'd3, 16'($urandom));
    random_block(80);

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pn2o_pkg.sv
sv/pn2o_cell.sv
sv/pn2o_div.sv
sv/perlin_noise_2d_octaves.sv
verif/pn2o_tb_pkg.sv
verif/perlin_noise_2d_octaves_checker.sv
verif/perlin_noise_2d_octaves_tb.sv
